@@ design/text_formatter_s_d_x_defines.svh @@
// ----------------------------------------------------------------------------
// text_formatter_s_d_x defines
// Assertion macros shared by the formatter RTL. Empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef TEXT_FORMATTER_S_D_X_DEFINES_SVH
`define TEXT_FORMATTER_S_D_X_DEFINES_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define TFSDX_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("tfsdx assertion failed");

// expression must never be true outside reset
`define TFSDX_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("tfsdx forbidden condition seen");

`else

`define TFSDX_ASSERT(lbl, clk, rstn, prop)
`define TFSDX_ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

@@ design/tfsdx_pkg.sv @@
// ----------------------------------------------------------------------------
// tfsdx_pkg
// Types, constants and character helpers for the %s/%d/%x text formatter.
// ----------------------------------------------------------------------------
package tfsdx_pkg;

  localparam int unsigned CmdW      = 3;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned ArgW      = 32;
  localparam int unsigned CountW    = 31;
  localparam int unsigned DigitsMax = 10;
  localparam int unsigned KW        = 4;
  localparam int unsigned NullLen   = 6;

  localparam logic [CountW-1:0] CountMax   = '1;
  localparam logic [ArgW-1:0]   RecipTen   = 32'hCCCC_CCCD;
  localparam int unsigned       RecipShift = 35;

  localparam logic [ByteW-1:0] ChPct   = 8'h25;
  localparam logic [ByteW-1:0] ChS     = 8'h73;
  localparam logic [ByteW-1:0] ChD     = 8'h64;
  localparam logic [ByteW-1:0] ChX     = 8'h78;
  localparam logic [ByteW-1:0] ChMinus = 8'h2d;

  typedef enum logic [CmdW-1:0] {
    CMD_FMT      = 3'd0,
    CMD_INT      = 3'd1,
    CMD_STR_BYTE = 3'd2,
    CMD_STR_END  = 3'd3,
    CMD_NULL     = 3'd4,
    CMD_FMT_END  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    AW_NONE = 2'd0,
    AW_STR  = 2'd1,
    AW_DEC  = 2'd2,
    AW_HEX  = 2'd3
  } await_e;

  typedef enum logic [2:0] {
    SEL_PCT,
    SEL_BYTE,
    SEL_NULL,
    SEL_MINUS,
    SEL_DIGIT,
    SEL_EMPTY,
    SEL_ERR
  } sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PCT,
    ST_BYTE,
    ST_DIV,
    ST_SIGN,
    ST_DIGITS,
    ST_NULL,
    ST_ERR,
    ST_EMPTY
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic ld_num;
    logic num_dec;
    logic div_step;
    logic emit;
    sel_e sel;
    logic last;
    logic cnt_clr;
  } ctrl_cmd_t;

  typedef struct packed {
    logic   in_valid;
    cmd_e   in_cmd;
    logic   in_is_pct;
    await_e in_conv;
    logic   item_fmt_end;
    logic   item_is_pct;
    logic   neg;
    logic   div_done;
    logic   k_nz;
    logic   k_last;
    logic   null_last;
    logic   out_free;
  } dp_status_t;

  function automatic logic [ByteW-1:0] digit_char(input logic [3:0] nib);
    logic [ByteW-1:0] ext;
    ext = {4'b0, nib};
    if (nib < 4'd10) begin
      return 8'h30 + ext;
    end
    return 8'h57 + ext;
  endfunction

  function automatic logic [ByteW-1:0] null_char(input logic [2:0] idx);
    logic [ByteW-1:0] ch;
    case (idx)
      3'd0:    ch = 8'h28;  // (
      3'd1:    ch = 8'h6e;  // n
      3'd2:    ch = 8'h75;  // u
      3'd3:    ch = 8'h6c;  // l
      3'd4:    ch = 8'h6c;  // l
      3'd5:    ch = 8'h29;  // )
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

@@ design/tfsdx_in_if.sv @@
// ----------------------------------------------------------------------------
// tfsdx_in_if
// Input channel: format bytes, string bytes and integer arguments.
// ----------------------------------------------------------------------------
interface tfsdx_in_if;
  logic                          valid;
  logic                          ready;
  logic [tfsdx_pkg::CmdW-1:0]    command;
  logic [tfsdx_pkg::ByteW-1:0]   text_byte;
  logic [tfsdx_pkg::ArgW-1:0]    arg_value;

  modport source (output valid, command, text_byte, arg_value, input ready);
  modport sink   (input valid, command, text_byte, arg_value, output ready);
endinterface

@@ design/tfsdx_out_if.sv @@
// ----------------------------------------------------------------------------
// tfsdx_out_if
// Output channel: one transaction per written character or status result.
// ----------------------------------------------------------------------------
interface tfsdx_out_if;
  logic                          valid;
  logic                          ready;
  logic [tfsdx_pkg::ByteW-1:0]   out_byte;
  logic                          byte_valid;
  logic                          last;
  logic [tfsdx_pkg::CountW-1:0]  total_count;
  logic                          error;

  modport source (output valid, out_byte, byte_valid, last, total_count, error,
                  input ready);
  modport sink   (input valid, out_byte, byte_valid, last, total_count, error,
                  output ready);
endinterface

@@ design/tfsdx_ctrl.sv @@
// ----------------------------------------------------------------------------
// tfsdx_ctrl
// Controller: decodes items against the conversion state and sequences
// character emission, digit generation and error results.
// ----------------------------------------------------------------------------
`include "text_formatter_s_d_x_defines.svh"

module tfsdx_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tfsdx_pkg::dp_status_t status_i,
  output tfsdx_pkg::ctrl_cmd_t  cmd_o
);

  tfsdx_pkg::state_e state_q, state_d;
  tfsdx_pkg::await_e await_q, await_d;
  logic              pct_q, pct_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tfsdx_pkg::ST_IDLE;
      await_q <= tfsdx_pkg::AW_NONE;
      pct_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      await_q <= await_d;
      pct_q   <= pct_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    await_d        = await_q;
    pct_d          = pct_q;
    cmd_o          = '0;
    cmd_o.sel      = tfsdx_pkg::SEL_EMPTY;

    case (state_q)
      tfsdx_pkg::ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (status_i.in_valid) begin
          case (status_i.in_cmd)
            tfsdx_pkg::CMD_FMT: begin
              if (await_q != tfsdx_pkg::AW_NONE) begin
                state_d = tfsdx_pkg::ST_ERR;
              end else if (pct_q) begin
                if (status_i.in_conv != tfsdx_pkg::AW_NONE) begin
                  await_d = status_i.in_conv;
                  pct_d   = 1'b0;
                end else begin
                  // stray percent is printed, byte then taken as fresh text
                  pct_d   = status_i.in_is_pct;
                  state_d = tfsdx_pkg::ST_PCT;
                end
              end else if (status_i.in_is_pct) begin
                pct_d = 1'b1;
              end else begin
                state_d = tfsdx_pkg::ST_BYTE;
              end
            end
            tfsdx_pkg::CMD_INT: begin
              if (await_q == tfsdx_pkg::AW_DEC || await_q == tfsdx_pkg::AW_HEX) begin
                cmd_o.ld_num  = 1'b1;
                cmd_o.num_dec = (await_q == tfsdx_pkg::AW_DEC);
                await_d       = tfsdx_pkg::AW_NONE;
                state_d       = tfsdx_pkg::ST_DIV;
              end else begin
                state_d = tfsdx_pkg::ST_ERR;
              end
            end
            tfsdx_pkg::CMD_STR_BYTE: begin
              if (await_q == tfsdx_pkg::AW_STR) begin
                state_d = tfsdx_pkg::ST_BYTE;
              end else begin
                state_d = tfsdx_pkg::ST_ERR;
              end
            end
            tfsdx_pkg::CMD_STR_END: begin
              if (await_q == tfsdx_pkg::AW_STR) begin
                await_d = tfsdx_pkg::AW_NONE;
              end else begin
                state_d = tfsdx_pkg::ST_ERR;
              end
            end
            tfsdx_pkg::CMD_NULL: begin
              if (await_q == tfsdx_pkg::AW_STR) begin
                await_d = tfsdx_pkg::AW_NONE;
                state_d = tfsdx_pkg::ST_NULL;
              end else begin
                state_d = tfsdx_pkg::ST_ERR;
              end
            end
            tfsdx_pkg::CMD_FMT_END: begin
              if (await_q != tfsdx_pkg::AW_NONE) begin
                state_d = tfsdx_pkg::ST_ERR;
              end else begin
                pct_d   = 1'b0;
                state_d = pct_q ? tfsdx_pkg::ST_PCT : tfsdx_pkg::ST_EMPTY;
              end
            end
            default: begin
              state_d = tfsdx_pkg::ST_ERR;
            end
          endcase
        end
      end

      tfsdx_pkg::ST_PCT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = tfsdx_pkg::SEL_PCT;
          if (status_i.item_fmt_end) begin
            cmd_o.last    = 1'b1;
            cmd_o.cnt_clr = 1'b1;
            state_d       = tfsdx_pkg::ST_IDLE;
          end else if (status_i.item_is_pct) begin
            cmd_o.last = 1'b1;
            state_d    = tfsdx_pkg::ST_IDLE;
          end else begin
            state_d = tfsdx_pkg::ST_BYTE;
          end
        end
      end

      tfsdx_pkg::ST_BYTE: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = tfsdx_pkg::SEL_BYTE;
          cmd_o.last = 1'b1;
          state_d    = tfsdx_pkg::ST_IDLE;
        end
      end

      tfsdx_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) begin
          state_d = status_i.neg ? tfsdx_pkg::ST_SIGN : tfsdx_pkg::ST_DIGITS;
        end
      end

      tfsdx_pkg::ST_SIGN: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = tfsdx_pkg::SEL_MINUS;
          state_d    = tfsdx_pkg::ST_DIGITS;
        end
      end

      tfsdx_pkg::ST_DIGITS: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = tfsdx_pkg::SEL_DIGIT;
          cmd_o.last = status_i.k_last;
          if (status_i.k_last) begin
            state_d = tfsdx_pkg::ST_IDLE;
          end
        end
      end

      tfsdx_pkg::ST_NULL: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = tfsdx_pkg::SEL_NULL;
          cmd_o.last = status_i.null_last;
          if (status_i.null_last) begin
            state_d = tfsdx_pkg::ST_IDLE;
          end
        end
      end

      tfsdx_pkg::ST_ERR: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = tfsdx_pkg::SEL_ERR;
          cmd_o.last = 1'b1;
          state_d    = tfsdx_pkg::ST_IDLE;
        end
      end

      tfsdx_pkg::ST_EMPTY: begin
        if (status_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.sel     = tfsdx_pkg::SEL_EMPTY;
          cmd_o.last    = 1'b1;
          cmd_o.cnt_clr = 1'b1;
          state_d       = tfsdx_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = tfsdx_pkg::ST_IDLE;
      end
    endcase
  end

  `TFSDX_ASSERT_NEVER(a_emit_needs_room, clk_i, rst_ni, cmd_o.emit && !status_i.out_free)
  `TFSDX_ASSERT_NEVER(a_await_no_pct, clk_i, rst_ni, (await_q != tfsdx_pkg::AW_NONE) && pct_q)
  `TFSDX_ASSERT(a_digits_left, clk_i, rst_ni, (state_q == tfsdx_pkg::ST_DIGITS) |-> status_i.k_nz)

endmodule

@@ design/tfsdx_dp.sv @@
// ----------------------------------------------------------------------------
// tfsdx_dp
// Datapath: item capture, digit generation (reciprocal divide by ten or
// nibble shift), digit buffer, saturating character count, output register.
// ----------------------------------------------------------------------------
`include "text_formatter_s_d_x_defines.svh"

module tfsdx_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tfsdx_in_if.sink              in_i,
  tfsdx_out_if.source           out_o,
  input  tfsdx_pkg::ctrl_cmd_t  cmd_i,
  output tfsdx_pkg::dp_status_t status_o
);

  localparam logic [tfsdx_pkg::KW-1:0] KMax     = tfsdx_pkg::KW'(tfsdx_pkg::DigitsMax);
  localparam logic [tfsdx_pkg::KW-1:0] KNullEnd = tfsdx_pkg::KW'(tfsdx_pkg::NullLen - 1);

  logic                          in_acc;

  logic [tfsdx_pkg::ByteW-1:0]   item_byte_q;
  logic [tfsdx_pkg::CmdW-1:0]    item_cmd_q;
  logic [tfsdx_pkg::ArgW-1:0]    mag_q, mag_d;
  logic                          neg_q, neg_d;
  logic                          dec_q;
  logic [tfsdx_pkg::KW-1:0]      k_q, k_d;
  logic [3:0]                    digit_q [tfsdx_pkg::DigitsMax];
  logic [tfsdx_pkg::CountW-1:0]  count_q, count_d;

  logic                          out_valid_q, out_valid_d;
  logic [tfsdx_pkg::ByteW-1:0]   out_byte_q;
  logic                          out_bv_q;
  logic                          out_last_q;
  logic [tfsdx_pkg::CountW-1:0]  out_count_q;
  logic                          out_err_q;

  logic [2*tfsdx_pkg::ArgW-1:0]  prod;
  logic [tfsdx_pkg::ArgW-1:0]    q_dec, ten_q, q_next;
  logic [3:0]                    rem;
  logic [tfsdx_pkg::KW-1:0]      k_rd;

  logic [tfsdx_pkg::ByteW-1:0]   emit_byte;
  logic                          emit_bv;
  logic                          emit_err;
  logic [tfsdx_pkg::CountW-1:0]  count_inc, count_new;

  assign in_i.ready = cmd_i.in_ready;
  assign in_acc     = in_i.valid && cmd_i.in_ready;

  // divide by ten: multiply by reciprocal, remainder from low bits
  assign prod  = {{tfsdx_pkg::ArgW{1'b0}}, mag_q} *
                 {{tfsdx_pkg::ArgW{1'b0}}, tfsdx_pkg::RecipTen};
  assign q_dec = tfsdx_pkg::ArgW'(prod >> tfsdx_pkg::RecipShift);
  assign ten_q = (q_dec << 3) + (q_dec << 1);

  always_comb begin
    if (dec_q) begin
      q_next = q_dec;
      rem    = 4'(mag_q - ten_q);
    end else begin
      q_next = mag_q >> 4;
      rem    = mag_q[3:0];
    end
  end

  assign k_rd = k_q - 1'b1;

  always_comb begin
    emit_byte = '0;
    emit_bv   = 1'b1;
    emit_err  = 1'b0;
    case (cmd_i.sel)
      tfsdx_pkg::SEL_PCT:   emit_byte = tfsdx_pkg::ChPct;
      tfsdx_pkg::SEL_BYTE:  emit_byte = item_byte_q;
      tfsdx_pkg::SEL_NULL:  emit_byte = tfsdx_pkg::null_char(k_q[2:0]);
      tfsdx_pkg::SEL_MINUS: emit_byte = tfsdx_pkg::ChMinus;
      tfsdx_pkg::SEL_DIGIT: emit_byte = tfsdx_pkg::digit_char(digit_q[k_rd]);
      tfsdx_pkg::SEL_ERR: begin
        emit_bv  = 1'b0;
        emit_err = 1'b1;
      end
      default: begin
        emit_bv = 1'b0;
      end
    endcase
  end

  assign count_inc = (count_q == tfsdx_pkg::CountMax) ? count_q : count_q + 1'b1;
  assign count_new = emit_bv ? count_inc : count_q;

  always_comb begin
    mag_d       = mag_q;
    neg_d       = neg_q;
    k_d         = k_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;

    if (in_acc) begin
      k_d = '0;
    end
    if (cmd_i.ld_num) begin
      neg_d = cmd_i.num_dec && in_i.arg_value[tfsdx_pkg::ArgW-1];
      mag_d = neg_d ? (~in_i.arg_value + 1'b1) : in_i.arg_value;
    end
    if (cmd_i.div_step) begin
      mag_d = q_next;
      k_d   = k_q + 1'b1;
    end

    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      count_d     = cmd_i.cnt_clr ? '0 : count_new;
      if (cmd_i.sel == tfsdx_pkg::SEL_NULL) begin
        k_d = k_q + 1'b1;
      end else if (cmd_i.sel == tfsdx_pkg::SEL_DIGIT) begin
        k_d = k_rd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      k_q         <= k_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    neg_q <= neg_d;
    if (in_acc) begin
      item_byte_q <= in_i.text_byte;
      item_cmd_q  <= in_i.command;
    end
    if (cmd_i.ld_num) begin
      dec_q <= cmd_i.num_dec;
    end
    if (cmd_i.div_step) begin
      digit_q[k_q] <= rem;
    end
    if (cmd_i.emit) begin
      out_byte_q  <= emit_byte;
      out_bv_q    <= emit_bv;
      out_last_q  <= cmd_i.last;
      out_count_q <= count_new;
      out_err_q   <= emit_err;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_byte    = out_byte_q;
  assign out_o.byte_valid  = out_bv_q;
  assign out_o.last        = out_last_q;
  assign out_o.total_count = out_count_q;
  assign out_o.error       = out_err_q;

  always_comb begin
    status_o              = '0;
    status_o.in_valid     = in_i.valid;
    status_o.in_cmd       = tfsdx_pkg::cmd_e'(in_i.command);
    status_o.in_is_pct    = (in_i.text_byte == tfsdx_pkg::ChPct);
    status_o.in_conv      = tfsdx_pkg::AW_NONE;
    case (in_i.text_byte)
      tfsdx_pkg::ChS: status_o.in_conv = tfsdx_pkg::AW_STR;
      tfsdx_pkg::ChD: status_o.in_conv = tfsdx_pkg::AW_DEC;
      tfsdx_pkg::ChX: status_o.in_conv = tfsdx_pkg::AW_HEX;
      default:        status_o.in_conv = tfsdx_pkg::AW_NONE;
    endcase
    status_o.item_fmt_end = (item_cmd_q == tfsdx_pkg::CMD_FMT_END);
    status_o.item_is_pct  = (item_byte_q == tfsdx_pkg::ChPct);
    status_o.neg          = neg_q;
    // stop on zero quotient or when the buffer is about to fill
    status_o.div_done     = (q_next == '0) || (k_q == KMax - 1'b1);
    status_o.k_nz         = (k_q != '0);
    status_o.k_last       = (k_q == tfsdx_pkg::KW'(1));
    status_o.null_last    = (k_q == KNullEnd);
    status_o.out_free     = !out_valid_q || out_o.ready;
  end

  `TFSDX_ASSERT(a_count_after_char, clk_i, rst_ni, (out_valid_q && out_bv_q) |-> (out_count_q != '0))
  `TFSDX_ASSERT_NEVER(a_k_range, clk_i, rst_ni, k_q > KMax)
  `TFSDX_ASSERT(a_div_room, clk_i, rst_ni, cmd_i.div_step |-> (k_q < KMax))

endmodule

@@ design/text_formatter_s_d_x.sv @@
// ----------------------------------------------------------------------------
// text_formatter_s_d_x
// Streaming printf-style formatter for %s, %d and %x conversions.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one format byte, string byte, string end, null string,
//   integer argument or format end per transaction. out_o carries one
//   transaction per character written, error or empty format-end result,
//   each with the running saturating count; last marks the final result
//   of an input item, error marks an out-of-order item that was dropped.
//   One item is handled at a time. A text byte is accepted, then loaded
//   into the output register; a '%' that opens a conversion, conversion
//   letters and string end give no result. An integer of D digits is
//   accepted, takes a divide-by-ten or nibble-shift step per digit
//   (D <= 10) and emits an optional minus and its D digits. "(null)"
//   gives six characters. All go out through the single output register.
//   Reset clears the conversion state, the count and the output valid flag.
//   When out_o stalls, emission waits with the result held and in_i is
//   not ready until the current item has emitted all its results.
// ----------------------------------------------------------------------------
module text_formatter_s_d_x (
  input  logic        clk_i,
  input  logic        rst_ni,
  tfsdx_in_if.sink    in_i,
  tfsdx_out_if.source out_o
);

  tfsdx_pkg::ctrl_cmd_t  cmd;
  tfsdx_pkg::dp_status_t status;

  tfsdx_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  tfsdx_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .out_o    (out_o),
    .cmd_i    (cmd),
    .status_o (status)
  );

endmodule
